/* rtl/i2cbm_pkg.sv */
// Shared types and constants for the I2C byte master.
// Used by every module of the block; depends on nothing.
`default_nettype none

package i2cbm_pkg;

  // Command codes
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_START = 4'd1;
  localparam logic [3:0] OP_STOP  = 4'd2;
  localparam logic [3:0] OP_WRITE = 4'd3;
  localparam logic [3:0] OP_CHECK = 4'd4;
  localparam logic [3:0] OP_READ  = 4'd5;
  localparam logic [3:0] OP_ACK   = 4'd6;
  localparam logic [3:0] OP_NACK  = 4'd7;
  localparam logic [3:0] OP_PROBE = 4'd8;

  // Probe segment boundaries (phase index)
  localparam logic [5:0] PRB_WR_BASE  = 6'd3;
  localparam logic [5:0] PRB_CHK_BASE = 6'd27;
  localparam logic [5:0] PRB_STP_BASE = 6'd30;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd200;

  // Decoupling queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  // Configuration register index
  localparam logic REG_PHASE_TICKS = 1'b0;

  // One classified input beat
  typedef struct packed {
    logic       cmd_valid;  // op is a known command
    logic       is_probe;
    logic       bus_idle;   // both lines sampled high
    logic [3:0] op;
    logic [7:0] wdata;
    logic       sda;
  } item_t;

  // Number of bus phases per command
  function automatic logic [5:0] op_phases(input logic [3:0] op);
    logic [5:0] n;
    case (op)
      OP_START: n = 6'd3;
      OP_STOP:  n = 6'd2;
      OP_WRITE: n = 6'd24;
      OP_CHECK: n = 6'd3;
      OP_READ:  n = 6'd16;
      OP_ACK:   n = 6'd3;
      OP_NACK:  n = 6'd3;
      OP_PROBE: n = 6'd32;
      default:  n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/i2cbm_front.sv */
// Front end: takes input beats and classifies the command.
// Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_front
  import i2cbm_pkg::*;
(
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [3:0] op_i,
  input  wire logic [7:0] wdata_i,
  input  wire logic       sda_in_i,
  input  wire logic       scl_in_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output item_t           q_item_o
);

  // Stall only when the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the beat
  always_comb begin
    q_item_o.cmd_valid = (op_i >= OP_START) && (op_i <= OP_PROBE);
    q_item_o.is_probe  = (op_i == OP_PROBE);
    q_item_o.bus_idle  = sda_in_i && scl_in_i;
    q_item_o.op        = op_i;
    q_item_o.wdata     = wdata_i;
    q_item_o.sda       = sda_in_i;
  end

endmodule

`default_nettype wire

/* rtl/i2cbm_queue.sv */
// Short FIFO of classified beats between front and back.
// Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_queue
  import i2cbm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  item_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - Q_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2cbm_back.sv */
// Back end: bus phase sequencer, one tick per queued beat, with output register.
// Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_back
  import i2cbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] phase_ticks_i,
  input  wire logic        q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       read_data_o,
  output logic             ack_bit_o,
  output logic             bus_error_o
);

  logic [15:0] timer_q, timer_d;
  logic [5:0]  idx_q, idx_d;
  logic [3:0]  act_q, act_d;
  logic [7:0]  sho_q, sho_d;
  logic [7:0]  shi_q, shi_d;
  logic        ack_q, ack_d;
  logic        err_q, err_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        done_q, done_d;
  logic        oval_q, oval_d;

  logic        step;
  logic [15:0] pt;
  logic [16:0] t_next;
  logic [5:0]  nxt;
  logic        run;
  logic [3:0]  sel_op;
  logic [5:0]  sel_idx;
  logic [3:0]  kind;
  logic [4:0]  sub;
  logic [8:0]  wr_prod;
  logic [3:0]  wr_bit;
  logic [4:0]  wr_r;

  // Advance one tick whenever a queued beat is waiting and the output register is free or drains
  assign step    = q_valid_i && (!oval_q || !out_stall_i);
  assign q_pop_o = step;
  assign pt      = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;

  // Bit number and position within a bit for the write sequence (sub / 3, sub % 3)
  assign wr_prod = 9'(sub) * 9'd11;
  assign wr_bit  = wr_prod[8:5];
  assign wr_r    = sub - ({1'b0, wr_bit} + {wr_bit, 1'b0});

  // One tick of the timing engine
  always_comb begin
    timer_d = timer_q;
    idx_d   = idx_q;
    act_d   = act_q;
    sho_d   = sho_q;
    shi_d   = shi_q;
    ack_d   = ack_q;
    err_d   = err_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done_d  = 1'b0;
    run     = 1'b0;
    sel_op  = act_q;
    sel_idx = idx_q;
    t_next  = {1'b0, timer_q} + 17'd1;
    nxt     = idx_q + 6'd1;
    kind    = OP_NONE;
    sub     = '0;

    if (act_q == OP_NONE) begin
      if (q_item_i.cmd_valid) begin
        if (q_item_i.is_probe && !q_item_i.bus_idle) begin
          // probe on a busy bus: flag and finish at once
          err_d  = 1'b1;
          ack_d  = 1'b1;
          done_d = 1'b1;
        end else begin
          if (q_item_i.is_probe) begin
            err_d = 1'b0;
          end
          act_d   = q_item_i.op;
          idx_d   = '0;
          timer_d = '0;
          sho_d   = q_item_i.wdata;
          if (q_item_i.op == OP_READ) begin
            shi_d = '0;
          end
          run     = 1'b1;
          sel_op  = q_item_i.op;
          sel_idx = '0;
        end
      end
    end else if (t_next >= {1'b0, pt}) begin
      if (nxt >= op_phases(act_q)) begin
        if (act_q == OP_ACK) begin
          sda_d = 1'b1;
        end
        act_d   = OP_NONE;
        idx_d   = '0;
        timer_d = '0;
        done_d  = 1'b1;
      end else begin
        idx_d   = nxt;
        timer_d = '0;
        run     = 1'b1;
        sel_idx = nxt;
      end
    end else begin
      timer_d = t_next[15:0];
    end

    // Map a probe phase onto its sub-command
    if (sel_op == OP_PROBE) begin
      if (sel_idx < PRB_WR_BASE) begin
        kind = OP_START;
        sub  = sel_idx[4:0];
      end else if (sel_idx < PRB_CHK_BASE) begin
        kind = OP_WRITE;
        sub  = 5'(sel_idx - PRB_WR_BASE);
      end else if (sel_idx < PRB_STP_BASE) begin
        kind = OP_CHECK;
        sub  = 5'(sel_idx - PRB_CHK_BASE);
      end else begin
        kind = OP_STOP;
        sub  = 5'(sel_idx - PRB_STP_BASE);
      end
    end else begin
      kind = sel_op;
      sub  = sel_idx[4:0];
    end

    // Line drives at phase start
    if (run) begin
      case (kind)
        OP_START: begin
          if (sub == 5'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (sub == 5'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        OP_STOP: begin
          if (sub == 5'd0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        OP_WRITE: begin
          if (wr_r == 5'd0) begin
            sda_d = sho_d[7];
          end else if (wr_r == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            if (wr_bit == 4'd7) begin
              sda_d = 1'b1;  // release SDA for the ack slot
            end
            sho_d = {sho_d[6:0], 1'b0};
          end
        end
        OP_CHECK: begin
          if (sub == 5'd0) begin
            sda_d = 1'b1;
          end else if (sub == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            ack_d = q_item_i.sda;
            scl_d = 1'b0;
          end
        end
        OP_READ: begin
          if (!sub[0]) begin
            scl_d = 1'b1;
          end else begin
            shi_d = {shi_d[6:0], q_item_i.sda};
            scl_d = 1'b0;
          end
        end
        OP_ACK: begin
          if (sub == 5'd0) begin
            sda_d = 1'b0;
          end else if (sub == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        OP_NACK: begin
          if (sub == 5'd0) begin
            sda_d = 1'b1;
          end else if (sub == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign oval_d = step || (oval_q && out_stall_i);

  // State doubles as the output register: it only moves on a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      idx_q   <= '0;
      act_q   <= OP_NONE;
      sho_q   <= '0;
      shi_q   <= '0;
      ack_q   <= 1'b1;
      err_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      done_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      oval_q <= oval_d;
      if (step) begin
        timer_q <= timer_d;
        idx_q   <= idx_d;
        act_q   <= act_d;
        sho_q   <= sho_d;
        shi_q   <= shi_d;
        ack_q   <= ack_d;
        err_q   <= err_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        done_q  <= done_d;
      end
    end
  end

  assign out_valid_o = oval_q;
  assign scl_out_o   = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = (act_q != OP_NONE);
  assign done_res_o  = done_q;
  assign read_data_o = shi_q;
  assign ack_bit_o   = ack_q;
  assign bus_error_o = err_q;

endmodule

`default_nettype wire

/* rtl/i2c_byte_master_top.sv */
// I2C byte master. An accepted beat passes the queue and the back-end state register.
// Throughput: one beat per cycle unless the output stalls; each beat is one bus tick,
// the back-end phase sequencer retires one queued beat per cycle via a 2-entry queue.
// Reset: asynchronous active low; lines released, idle, ack 1, phase_ticks 200.
// Depends on i2cbm_pkg, i2cbm_front, i2cbm_queue, i2cbm_back.
`default_nettype none

module i2c_byte_master_top
  import i2cbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [7:0]  wdata_i,
  input  wire logic        sda_in_i,
  input  wire logic        scl_in_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       read_data_o,
  output logic             ack_bit_o,
  output logic             bus_error_o
);

  logic [15:0] ticks_q;
  logic        q_full, q_push, q_pop, q_valid;
  item_t       f_item, b_item;

  // Register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PHASE_TICKS) ? {16'd0, ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PHASE_TICKS_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PHASE_TICKS)) begin
      ticks_q <= pwdata[15:0];
    end
  end

  i2cbm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .wdata_i    (wdata_i),
    .sda_in_i   (sda_in_i),
    .scl_in_i   (scl_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (f_item)
  );

  i2cbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (b_item)
  );

  i2cbm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (ticks_q),
    .q_valid_i     (q_valid),
    .q_item_i      (b_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_out_o     (scl_out_o),
    .sda_out_o     (sda_out_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .read_data_o   (read_data_o),
    .ack_bit_o     (ack_bit_o),
    .bus_error_o   (bus_error_o)
  );

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !busy_res_o)
    else $error("done beat while still busy");

  // Busy only drops on the tick that reports completion
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_res_o) |-> (done_res_o && out_valid_o))
    else $error("busy dropped without done");

  // A bus error is only raised by a probe that finishes at once
  a_err_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(bus_error_o) |-> (done_res_o && out_valid_o && !busy_res_o))
    else $error("bus error raised outside a rejected probe");

endmodule

`default_nettype wire
